/* src/hvt_pkg.sv */
package hvt_pkg;

  localparam int CoordW = 32;
  localparam int ProdW  = 64;
  localparam int AccW   = 66;
  localparam int DivW   = 64;
  localparam int NCells = 32;
  localparam int NRegs  = 8;

  localparam logic [CoordW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] SatNeg = 32'h8000_0000;

  // One coordinate in flight through the divider chain
  typedef struct packed {
    logic [DivW-1:0]   rem;
    logic [CoordW-1:0] num;
    logic [CoordW-1:0] q;
    logic              neg;
    logic              ovf;
    logic [CoordW-1:0] zval;
    logic              zsat;
  } lane_t;

  typedef struct packed {
    logic             vld;
    logic             wzero;
    logic [DivW-1:0]  d;
    lane_t [2:0]      ln;
  } divw_t;

  typedef logic [3:0][3:0][CoordW-1:0] mat_t;

endpackage

/* src/hvt_cell.sv */
module hvt_cell
  import hvt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  divw_t i,
  output divw_t o
);

  logic [DivW:0] r  [3];
  logic [DivW:0] rs [3];
  logic          ge [3];
  divw_t         nxt;

  // one quotient bit per lane: shift in the next numerator bit, trial subtract
  always_comb begin
    nxt = i;
    for (int k = 0; k < 3; k++) begin
      r[k]  = {i.ln[k].rem, i.ln[k].num[CoordW-1]};
      ge[k] = r[k] >= {1'b0, i.d};
      rs[k] = ge[k] ? (r[k] - {1'b0, i.d}) : r[k];
      nxt.ln[k].rem = rs[k][DivW-1:0];
      nxt.ln[k].num = {i.ln[k].num[CoordW-2:0], 1'b0};
      nxt.ln[k].q   = {i.ln[k].q[CoordW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o.vld <= 1'b0;
    end else if (en) begin
      o.vld <= nxt.vld;
    end
    if (en) begin
      o.wzero <= nxt.wzero;
      o.d     <= nxt.d;
      o.ln    <= nxt.ln;
    end
  end

endmodule

/* src/hvt_front.sv */
module hvt_front
  import hvt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [CoordW-1:0] x,
  input  logic [CoordW-1:0] y,
  input  logic [CoordW-1:0] z,
  input  mat_t              m,
  output divw_t             o
);

  localparam int NW = DivW + FRAC_BITS;

  // stage 1: products
  logic                     v1;
  logic signed [ProdW-1:0]  p1 [3][4];
  // stage 2: sums
  logic                     v2;
  logic signed [AccW-1:0]   a2 [4];
  // stage 3: magnitudes
  logic                     v3;
  logic        [DivW-1:0]   mag3 [4];
  logic                     sgn3 [4];
  logic signed [AccW-1:0]   zs3  [3];
  logic                     wz3;

  logic        [CoordW-1:0] vin [3];
  logic signed [AccW-1:0]   acc_next [4];
  logic signed [AccW-1:0]   neg_acc [4];
  logic        [NW-1:0]     n4 [3];
  logic        [NW-33:0]    hi4 [3];
  logic                     zin [3];
  divw_t                    o_next;

  assign vin[0] = x;
  assign vin[1] = y;
  assign vin[2] = z;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_next[c] = {{(AccW-ProdW){p1[0][c][ProdW-1]}}, p1[0][c]}
                  + {{(AccW-ProdW){p1[1][c][ProdW-1]}}, p1[1][c]}
                  + {{(AccW-ProdW){p1[2][c][ProdW-1]}}, p1[2][c]}
                  + ({{(AccW-CoordW){m[3][c][CoordW-1]}}, m[3][c]} <<< FRAC_BITS);
      neg_acc[c] = -a2[c];
    end
  end

  always_comb begin
    o_next       = '0;
    o_next.vld   = v3;
    o_next.wzero = wz3;
    o_next.d     = mag3[3];
    for (int c = 0; c < 3; c++) begin
      n4[c]  = {mag3[c], {FRAC_BITS{1'b0}}};
      hi4[c] = n4[c][NW-1:CoordW];
      zin[c] = (zs3[c][AccW-1:CoordW-1] == '0) || (zs3[c][AccW-1:CoordW-1] == '1);
      o_next.ln[c].rem  = DivW'(hi4[c]);
      o_next.ln[c].num  = n4[c][CoordW-1:0];
      o_next.ln[c].q    = '0;
      o_next.ln[c].neg  = sgn3[c] ^ sgn3[3];
      o_next.ln[c].ovf  = DivW'(hi4[c]) >= mag3[3];
      o_next.ln[c].zval = zin[c] ? zs3[c][CoordW-1:0]
                                 : (zs3[c][AccW-1] ? SatNeg : SatPos);
      o_next.ln[c].zsat = !zin[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      o.vld <= 1'b0;
    end else if (en) begin
      v1    <= in_vld;
      v2    <= v1;
      v3    <= v2;
      o.vld <= o_next.vld;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          p1[r][c] <= signed'(vin[r]) * signed'(m[r][c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        a2[c]   <= acc_next[c];
        sgn3[c] <= a2[c][AccW-1];
        mag3[c] <= a2[c][AccW-1] ? neg_acc[c][DivW-1:0] : a2[c][DivW-1:0];
      end
      for (int c = 0; c < 3; c++) begin
        zs3[c] <= a2[c] >>> FRAC_BITS;
      end
      wz3     <= (a2[3] == '0);
      o.wzero <= o_next.wzero;
      o.d     <= o_next.d;
      o.ln    <= o_next.ln;
    end
  end

endmodule

/* src/homogeneous_vertex_transform.sv */
// Homogeneous vertex transform, 4x4 matrix with perspective divide.
// Input stream (s_*): one vertex per request, tdata = {z, y, x}, signed
// fixed point with FRAC_BITS fraction bits. The vertex (x, y, z, 1) is
// multiplied by the matrix loaded over the APB port (eight 64-bit registers
// at 8*i, two matrix entries each); x, y, z are divided by the computed w.
// Output stream (m_*): tdata = {z, y, x}, tuser = {saturated, w_was_zero}.
// When w is zero the sums are shifted down instead of divided.
// Pipeline stages: products, sums, magnitudes, divide setup, 32
// divider cells (one quotient bit each, three coordinates in parallel)
// and the output register. Throughput is one vertex per cycle.
// The whole pipeline advances whenever the output register is empty or
// being taken; a stalled receiver holds every stage and deasserts s_tready.
// Reset empties the pipeline and loads the identity matrix. The user must
// make matrix writes only while no vertex is in flight; nothing enforces it.
module homogeneous_vertex_transform
  import hvt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // vertex in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
  // vertex out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [1:0]  m_tuser    // w_was_zero [0], saturated [1]
);

  logic [63:0] regs [NRegs];
  mat_t        m;
  logic        en;
  divw_t       ch [NCells+1];
  logic [CoordW-1:0] val_next [3];
  logic              sat_next [3];
  divw_t             tl;

  localparam logic [63:0] One = 64'(1) << FRAC_BITS;

  assign pready = 1'b1;
  assign prdata = regs[paddr[5:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= One;
      regs[1] <= '0;
      regs[2] <= One << 32;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= One;
      regs[6] <= '0;
      regs[7] <= One << 32;
    end else if (psel && penable && pwrite && pready) begin
      regs[paddr[5:3]] <= pwdata;
    end
  end

  // register 2r holds columns 0/1 of row r, register 2r+1 columns 2/3
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? regs[r*2 + c/2][63:32] : regs[r*2 + c/2][31:0];
      end
    end
  end

  // global advance: output register free or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hvt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid),
    .x      (s_tdata[31:0]),
    .y      (s_tdata[63:32]),
    .z      (s_tdata[95:64]),
    .m      (m),
    .o      (ch[0])
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    hvt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .i   (ch[g]),
      .o   (ch[g+1])
    );
  end

  assign tl = ch[NCells];

  // sign and clamp the quotient, or take the shifted value when w is zero
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (tl.wzero) begin
        val_next[c] = tl.ln[c].zval;
        sat_next[c] = tl.ln[c].zsat;
      end else if (tl.ln[c].neg) begin
        sat_next[c] = tl.ln[c].ovf || (tl.ln[c].q > SatNeg);
        val_next[c] = sat_next[c] ? SatNeg : (CoordW'(0) - tl.ln[c].q);
      end else begin
        sat_next[c] = tl.ln[c].ovf || tl.ln[c].q[CoordW-1];
        val_next[c] = sat_next[c] ? SatPos : tl.ln[c].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= tl.vld;
    end
    if (en) begin
      m_tdata <= {val_next[2], val_next[1], val_next[0]};
      m_tuser <= {sat_next[0] || sat_next[1] || sat_next[2], tl.wzero};
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |->
      (m_tdata[31:0] == SatPos || m_tdata[31:0] == SatNeg ||
       m_tdata[63:32] == SatPos || m_tdata[63:32] == SatNeg ||
       m_tdata[95:64] == SatPos || m_tdata[95:64] == SatNeg))
    else $error("saturation flag without clamped value");

endmodule
